### rtl/core/stack_allocator_with_headers_assert.svh
// Assertion macros for the bound checker module sah_checker.
`ifndef STACK_ALLOCATOR_WITH_HEADERS_ASSERT_SVH
`define STACK_ALLOCATOR_WITH_HEADERS_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SAH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sah_pkg.sv
package sah_pkg;

  localparam int unsigned BUFFER_BYTES_DEF   = 65536;
  localparam int unsigned HEADER_BYTES_DEF   = 16;
  localparam int unsigned MAX_ALIGN_LOG2_DEF = 12;

  localparam int OFFSET_W = 17;
  localparam int SIZE_W   = 17;
  localparam int ALIGN_W  = 4;
  localparam int FREE_W   = 16;
  localparam int ACTION_W = 2;
  localparam int PAD_W    = 13;
  localparam int CALC_W   = 20;
  localparam int HDR_W    = PAD_W + OFFSET_W;
  localparam int BASE_W   = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [ACTION_W-1:0] ACT_ALLOC    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE_ALL = 2'd2;

  localparam logic REG_BUFFER_BASE   = 1'b0;
  localparam logic REG_BUFFER_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_SPACE  = 2'd1,
    ST_OUT_OF_BOUNDS = 2'd2,
    ST_ALREADY_FREED = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

### rtl/core/sah_channels.sv
interface sah_req_if;
  import sah_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SIZE_W-1:0]   request_size;
  logic [ALIGN_W-1:0]  alignment_log2;
  logic [FREE_W-1:0]   free_offset;

  modport source(output valid, action, request_size, alignment_log2, free_offset,
                 input ready);
  modport sink(input valid, action, request_size, alignment_log2, free_offset,
               output ready);
endinterface

interface sah_rsp_if;
  import sah_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] block_offset;
  status_t             status;

  modport source(output valid, block_offset, status, input ready);
  modport sink(input valid, block_offset, status, output ready);
endinterface

### rtl/core/sah_pad_calc.sv
module sah_pad_calc #(
  parameter int unsigned HEADER_BYTES   = sah_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_ALIGN_LOG2 = sah_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic [sah_pkg::BASE_W-1:0]   base,
  input  logic [sah_pkg::OFFSET_W-1:0] top,
  input  logic [sah_pkg::ALIGN_W-1:0]  lg,
  output logic [sah_pkg::CALC_W-1:0]   pad
);
  import sah_pkg::*;

  localparam logic [ALIGN_W:0]   MAX_LG = (ALIGN_W + 1)'(MAX_ALIGN_LOG2);
  localparam logic [CALC_W-1:0]  HDR    = CALC_W'(HEADER_BYTES);

  logic [ALIGN_W-1:0] lg_sat;
  logic [FREE_W-1:0]  addr_low;
  logic [CALC_W-1:0]  align;
  logic [CALC_W-1:0]  modulo;
  logic [CALC_W-1:0]  pad0;
  logic [CALC_W-1:0]  need;
  logic [CALC_W-1:0]  extra;

  // Only the low address bits matter for alignment up to 2^15.
  always_comb begin
    lg_sat   = ({1'b0, lg} > MAX_LG) ? MAX_LG[ALIGN_W-1:0] : lg;
    addr_low = base[FREE_W-1:0] + top[FREE_W-1:0];
    align    = CALC_W'(1) << lg_sat;
    modulo   = {{(CALC_W - FREE_W){1'b0}}, addr_low} & (align - CALC_W'(1));
    pad0     = (modulo != '0) ? (align - modulo) : '0;
    need     = HDR - pad0;
    extra    = ((need + align - CALC_W'(1)) >> lg_sat) << lg_sat;
    pad      = (pad0 < HDR) ? (pad0 + extra) : pad0;
  end

endmodule

### rtl/core/stack_allocator_with_headers.sv
// A request is registered when accepted, worked out in the S_EXEC state, and its
// result held in an output register. No new request is taken while one is in
// S_EXEC or while an earlier result still waits for result.ready.
// Reset (rst, synchronous): top and previous top clear, base clears, length
// returns to 65536; the header memory is not cleared.
module stack_allocator_with_headers #(
  parameter int unsigned BUFFER_BYTES   = sah_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned HEADER_BYTES   = sah_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_ALIGN_LOG2 = sah_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  sah_req_if.sink                    request,
  sah_rsp_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sah_pkg::ADDR_W-1:0] paddr,
  input  logic [sah_pkg::DATA_W-1:0] pwdata,
  output logic [sah_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import sah_pkg::*;

  localparam int unsigned DEPTH   = (BUFFER_BYTES < 65536) ? BUFFER_BYTES : 65536;
  localparam int          AW      = $clog2(DEPTH);
  localparam int unsigned OFF_MAX = (1 << OFFSET_W) - 1;
  localparam int unsigned CAP     = (BUFFER_BYTES < OFF_MAX) ? BUFFER_BYTES : OFF_MAX;
  localparam logic [OFFSET_W-1:0] LEN_CAP   = OFFSET_W'(CAP);
  localparam logic [OFFSET_W-1:0] LEN_RESET = OFFSET_W'(65536);
  localparam logic [CALC_W-1:0]   DEPTH_C   = CALC_W'(DEPTH);

  state_t state, state_next;

  logic [BASE_W-1:0]   buffer_base;
  logic [OFFSET_W-1:0] buffer_length;
  logic [OFFSET_W-1:0] len_usable;
  logic [OFFSET_W-1:0] top_offset, top_next;
  logic [OFFSET_W-1:0] previous_top, previous_next;

  logic [ACTION_W-1:0] act_q;
  logic [SIZE_W-1:0]   size_q;
  logic [FREE_W-1:0]   foff_q;
  logic [CALC_W-1:0]   pad_q;
  logic [CALC_W-1:0]   pad_w;

  logic                out_valid;
  logic [OFFSET_W-1:0] out_block;
  status_t             out_status;
  logic [OFFSET_W-1:0] res_block;
  status_t             res_status;

  logic [HDR_W-1:0] hdr_mem [DEPTH];
  logic [HDR_W-1:0] rd_data;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [HDR_W-1:0] wr_data;

  logic              accept;
  logic              cfg_we;
  logic [CALC_W-1:0] start;
  logic [CALC_W-1:0] alloc_end;
  logic [OFFSET_W-1:0] wr_len;

  sah_pad_calc #(
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_ALIGN_LOG2(MAX_ALIGN_LOG2)
  ) u_pad (
    .base(buffer_base),
    .top (top_offset),
    .lg  (request.alignment_log2),
    .pad (pad_w)
  );

  assign accept = request.valid && request.ready;
  assign cfg_we = psel && penable && pwrite && pready;
  assign wr_len = pwdata[OFFSET_W-1:0];
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUFFER_BASE) ? buffer_base : DATA_W'(buffer_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base   <= '0;
      buffer_length <= LEN_RESET;
      len_usable    <= (LEN_RESET > LEN_CAP) ? LEN_CAP : LEN_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_BUFFER_BASE) begin
        buffer_base <= pwdata;
      end else begin
        buffer_length <= wr_len;
        len_usable    <= (wr_len > LEN_CAP) ? LEN_CAP : wr_len;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    request.ready = (state == S_IDLE) && (!out_valid || result.ready);
    start         = {{(CALC_W - OFFSET_W){1'b0}}, top_offset} + pad_q;
    alloc_end     = start + {{(CALC_W - SIZE_W){1'b0}}, size_q};
    top_next      = top_offset;
    previous_next = previous_top;
    res_block     = '0;
    res_status    = ST_OK;
    mem_we        = 1'b0;
    wr_addr       = start[AW-1:0];
    wr_data       = {pad_q[PAD_W-1:0], top_offset};
    if (state == S_EXEC) begin
      case (act_q)
        ACT_ALLOC: begin
          if (alloc_end > {{(CALC_W - OFFSET_W){1'b0}}, len_usable}) begin
            res_status = ST_OUT_OF_SPACE;
          end else begin
            previous_next = top_offset;
            top_next      = alloc_end[OFFSET_W-1:0];
            res_block     = start[OFFSET_W-1:0];
            mem_we        = (start < DEPTH_C);
          end
        end
        ACT_FREE: begin
          if ({1'b0, foff_q} >= len_usable) begin
            res_status = ST_OUT_OF_BOUNDS;
          end else if ({1'b0, foff_q} >= top_offset) begin
            res_status = ST_ALREADY_FREED;
          end else begin
            top_next      = previous_top;
            previous_next = rd_data[OFFSET_W-1:0];
          end
        end
        ACT_FREE_ALL: begin
          top_next = '0;
        end
        default: begin
          top_next = top_offset;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      top_offset   <= '0;
      previous_top <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      top_offset   <= top_next;
      previous_top <= previous_next;
      if (state == S_EXEC) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= request.action;
      size_q <= request.request_size;
      foff_q <= request.free_offset;
      pad_q  <= pad_w;
    end
    if (state == S_EXEC) begin
      out_block  <= res_block;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    rd_data <= hdr_mem[request.free_offset[AW-1:0]];
  end

  assign result.valid        = out_valid;
  assign result.block_offset = out_block;
  assign result.status       = out_status;

endmodule

### rtl/core/sah_checker.sv
`include "stack_allocator_with_headers_assert.svh"

module sah_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [sah_pkg::OFFSET_W-1:0] rsp_block_offset,
  input logic [1:0]                   rsp_status
);
  import sah_pkg::*;

  `SAH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_offset), "result dropped or changed while stalled")
  `SAH_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, ##1 rsp_valid, "no result two cycles after an accepted request")
  `SAH_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while another is in progress")
  `SAH_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != ST_OK), rsp_block_offset == '0, "failed request returned a nonzero offset")

endmodule

bind stack_allocator_with_headers sah_checker u_sah_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (request.valid),
  .req_ready       (request.ready),
  .rsp_valid       (result.valid),
  .rsp_ready       (result.ready),
  .rsp_block_offset(result.block_offset),
  .rsp_status      (result.status)
);

### dv/stack_allocator_with_headers_checker.sv
`timescale 1ns / 100ps
module stack_allocator_with_headers_checker
  import sah_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sah_req_if                request,
  sah_rsp_if                result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  input  logic              run_done,
  output int                fail_count
);

  localparam int MAX_PRINTED = 200;

  typedef struct {
    logic [OFFSET_W-1:0] block_offset;
    status_t             status;
  } grant_t;

  logic [BASE_W-1:0]   base_addr;
  logic [OFFSET_W-1:0] length_bytes;
  logic [OFFSET_W-1:0] top_offset;
  logic [OFFSET_W-1:0] previous_top;
  logic [HDR_W-1:0]    header_mem [BUFFER_BYTES_DEF];
  grant_t              pending_grants [$];
  grant_t              want;
  logic [DATA_W-1:0]   reg_expect;
  bit                  closed;

  int n_requests;
  int n_placed;
  int n_at_end;
  int n_no_space;
  int n_rolled_back;
  int n_out_of_bounds;
  int n_already_freed;
  int n_cleared;
  int n_ignored;
  int n_reg_writes;
  int n_reg_reads;

  initial begin
    fail_count      = 0;
    closed          = 1'b0;
    n_requests      = 0;
    n_placed        = 0;
    n_at_end        = 0;
    n_no_space      = 0;
    n_rolled_back   = 0;
    n_out_of_bounds = 0;
    n_already_freed = 0;
    n_cleared       = 0;
    n_ignored       = 0;
    n_reg_writes    = 0;
    n_reg_reads     = 0;
    foreach (header_mem[i]) header_mem[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [OFFSET_W-1:0] usable_length();
    return (length_bytes > BUFFER_BYTES_DEF) ? OFFSET_W'(BUFFER_BYTES_DEF) : length_bytes;
  endfunction

  function automatic logic [PAD_W-1:0] header_pad(input logic [BASE_W-1:0]  addr,
                                                  input logic [ALIGN_W-1:0] lg);
    logic [CALC_W-1:0] align;
    logic [CALC_W-1:0] modv;
    logic [CALC_W-1:0] pad;
    align = CALC_W'(1) << lg;
    modv  = CALC_W'(addr) & (align - 1'b1);
    pad   = (modv != '0) ? align - modv : '0;
    if (pad < HEADER_BYTES_DEF) begin
      pad += ((CALC_W'(HEADER_BYTES_DEF) - pad + align - 1'b1) >> lg) << lg;
    end
    return pad[PAD_W-1:0];
  endfunction

  function automatic grant_t apply_request(input logic [ACTION_W-1:0] action,
                                           input logic [SIZE_W-1:0]   size,
                                           input logic [ALIGN_W-1:0]  lg_in,
                                           input logic [FREE_W-1:0]   foff);
    grant_t             g;
    logic [ALIGN_W-1:0] lg;
    logic [PAD_W-1:0]   pad;
    logic [CALC_W-1:0]  start;
    logic [CALC_W-1:0]  limit;
    g.block_offset = '0;
    g.status       = ST_OK;
    lg    = (lg_in > MAX_ALIGN_LOG2_DEF) ? ALIGN_W'(MAX_ALIGN_LOG2_DEF) : lg_in;
    limit = CALC_W'(usable_length());
    case (action)
      ACT_ALLOC: begin
        pad   = header_pad(base_addr + BASE_W'(top_offset), lg);
        start = CALC_W'(top_offset) + CALC_W'(pad);
        if (start + CALC_W'(size) > limit) begin
          g.status = ST_OUT_OF_SPACE;
          n_no_space++;
        end else begin
          previous_top = top_offset;
          if (start < BUFFER_BYTES_DEF) begin
            header_mem[start[FREE_W-1:0]] = {pad, previous_top};
          end else begin
            n_at_end++;
          end
          top_offset     = OFFSET_W'(start + CALC_W'(size));
          g.block_offset = OFFSET_W'(start);
          n_placed++;
        end
      end
      ACT_FREE: begin
        if (CALC_W'(foff) >= limit) begin
          g.status = ST_OUT_OF_BOUNDS;
          n_out_of_bounds++;
        end else if (OFFSET_W'(foff) >= top_offset) begin
          g.status = ST_ALREADY_FREED;
          n_already_freed++;
        end else begin
          top_offset   = previous_top;
          previous_top = header_mem[foff][OFFSET_W-1:0];
          n_rolled_back++;
        end
      end
      ACT_FREE_ALL: begin
        top_offset = '0;
        n_cleared++;
      end
      default: begin
        n_ignored++;
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      base_addr    = '0;
      length_bytes = OFFSET_W'(BUFFER_BYTES_DEF);
      top_offset   = '0;
      previous_top = '0;
      pending_grants.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[ADDR_W-1:2] == REG_BUFFER_BASE) begin
            base_addr = pwdata[BASE_W-1:0];
          end else begin
            length_bytes = pwdata[OFFSET_W-1:0];
          end
          n_reg_writes++;
        end else begin
          reg_expect = (paddr[ADDR_W-1:2] == REG_BUFFER_BASE) ?
                       DATA_W'(base_addr) : DATA_W'(length_bytes);
          if (prdata !== reg_expect) begin
            report_mismatch($sformatf("register read at 0x%0h gave 0x%0h, want 0x%0h",
                                      paddr, prdata, reg_expect));
          end
          n_reg_reads++;
        end
      end

      if (request.valid && request.ready) begin
        pending_grants.push_back(apply_request(request.action, request.request_size,
                                               request.alignment_log2, request.free_offset));
        n_requests++;
      end

      if (result.valid && result.ready) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = pending_grants.pop_front();
          if (result.block_offset !== want.block_offset) begin
            report_mismatch($sformatf("block_offset %0d, want %0d",
                                      result.block_offset, want.block_offset));
          end
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %s",
                                      result.status, want.status.name()));
          end
        end
      end

      if (run_done && !closed) begin
        closed = 1'b1;
        if (pending_grants.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", pending_grants.size()));
        end
        $display("Covered %0d requests, %0d register writes and %0d reads: %0d blocks placed",
                 n_requests, n_reg_writes, n_reg_reads, n_placed);
        $display("(%0d at buffer end), %0d refused, %0d rollbacks, %0d out of bounds, %0d %s",
                 n_at_end, n_no_space, n_rolled_back, n_out_of_bounds, n_already_freed,
                 $sformatf("stale frees, %0d clears, %0d unknown actions", n_cleared,
                           n_ignored));
      end
    end
  end

endmodule

### dv/stack_allocator_with_headers_tb.sv
`timescale 1ns / 100ps
module stack_allocator_with_headers_tb;
  import sah_pkg::*;

  localparam int TIMEOUT_NS   = 3_000_000;
  localparam int LONG_STALL   = 64;
  localparam int STALL_AFTER  = 150;
  localparam int CALM_TAIL    = 150;
  localparam int RECENT_DEPTH = 8;
  localparam int NUM_PHASES   = 6;

  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              run_done;
  int                fail_count;

  sah_req_if req_ch();
  sah_rsp_if rsp_ch();

  int                  n_sent;
  int                  n_recv;
  bit                  calm;
  bit                  stall_done;
  bit                  hdr_seen [BUFFER_BYTES_DEF];
  logic [FREE_W-1:0]   hdr_list [$];
  logic [FREE_W-1:0]   recent_blocks [$];
  logic [FREE_W-1:0]   seen_off;
  logic [OFFSET_W-1:0] cur_len;

  stack_allocator_with_headers i_dut (
    .clk,
    .rst,
    .request (req_ch),
    .result  (rsp_ch),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  stack_allocator_with_headers_checker i_checker (
    .clk,
    .rst,
    .request (req_ch),
    .result  (rsp_ch),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .run_done,
    .fail_count
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // A free below the top reads the header at its offset, so random frees within the
  // buffer length take their offsets only from blocks that the block has actually placed.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) n_sent++;
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_recv++;
        if (rsp_ch.status == ST_OK && rsp_ch.block_offset != '0 &&
            rsp_ch.block_offset < BUFFER_BYTES_DEF) begin
          seen_off = rsp_ch.block_offset[FREE_W-1:0];
          if (!hdr_seen[seen_off]) begin
            hdr_seen[seen_off] = 1'b1;
            hdr_list.push_back(seen_off);
          end
          recent_blocks.push_back(seen_off);
          if (recent_blocks.size() > RECENT_DEPTH) void'(recent_blocks.pop_front());
        end
      end
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && n_recv >= STALL_AFTER) begin
        rsp_ch.ready <= 1'b0;
        stall_done = 1'b1;
        repeat (LONG_STALL - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic issue_request(input logic [ACTION_W-1:0] act,
                               input logic [SIZE_W-1:0]   size,
                               input logic [ALIGN_W-1:0]  lg,
                               input logic [FREE_W-1:0]   foff);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.action         <= act;
    req_ch.request_size   <= size;
    req_ch.alignment_log2 <= lg;
    req_ch.free_offset    <= foff;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return SIZE_W'($urandom_range(0, 255));
    if (pick < 93) return SIZE_W'($urandom_range(0, 4095));
    if (pick < 98) return SIZE_W'($urandom_range(0, 65535));
    return SIZE_W'(BUFFER_BYTES_DEF);
  endfunction

  task automatic issue_random_request();
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [SIZE_W-1:0]   size;
    logic [ALIGN_W-1:0]  lg;
    logic [FREE_W-1:0]   foff;
    pick = $urandom_range(0, 99);
    size = random_size();
    lg   = ALIGN_W'($urandom_range(0, 15));
    foff = FREE_W'($urandom);
    if (pick < 55) begin
      act = ACT_ALLOC;
    end else if (pick < 90) begin
      act = ACT_FREE;
      if (cur_len < BUFFER_BYTES_DEF && ($urandom_range(0, 3) == 0 || hdr_list.size() == 0)) begin
        foff = FREE_W'($urandom_range(cur_len, BUFFER_BYTES_DEF - 1));
      end else if (hdr_list.size() == 0) begin
        act = ACT_ALLOC;
      end else if (recent_blocks.size() != 0 && $urandom_range(0, 2) != 0) begin
        foff = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
      end else begin
        foff = hdr_list[$urandom_range(0, hdr_list.size() - 1)];
      end
    end else if (pick < 95) begin
      act = ACT_FREE_ALL;
    end else begin
      act = ACT_UNKNOWN;
    end
    issue_request(act, size, lg, foff);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (n_recv == n_sent);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic index,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_W'({index, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [BASE_W-1:0] base, input logic [OFFSET_W-1:0] len);
    apb_access(1'b1, REG_BUFFER_BASE, DATA_W'(base));
    apb_access(1'b1, REG_BUFFER_LENGTH, DATA_W'(len));
    apb_access(1'b0, REG_BUFFER_BASE, '0);
    apb_access(1'b0, REG_BUFFER_LENGTH, '0);
    cur_len = len;
  endtask

  initial begin
    logic [BASE_W-1:0]   base;
    logic [OFFSET_W-1:0] len;
    int                  items;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    run_done              = 1'b0;
    calm                  = 1'b0;
    stall_done            = 1'b0;
    n_sent                = 0;
    n_recv                = 0;
    cur_len               = OFFSET_W'(BUFFER_BYTES_DEF);
    req_ch.valid          = 1'b0;
    req_ch.action         = ACT_ALLOC;
    req_ch.request_size   = '0;
    req_ch.alignment_log2 = '0;
    req_ch.free_offset    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_access(1'b0, REG_BUFFER_BASE, '0);
    apb_access(1'b0, REG_BUFFER_LENGTH, '0);

    // Walk through padding, stale frees, the header rollback quirk, an exact
    // fit and a size-zero block placed right at the end of the buffer.
    issue_request(ACT_ALLOC, 17'd0, 4'd0, '0);
    issue_request(ACT_ALLOC, 17'd1, 4'd15, '0);
    issue_request(ACT_ALLOC, 17'd65536, 4'd0, '0);
    issue_request(ACT_UNKNOWN, 17'd65536, 4'd15, 16'hFFFF);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'hFFFF);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'd4096);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'd4096);
    issue_request(ACT_ALLOC, 17'd100, 4'd4, '0);
    issue_request(ACT_ALLOC, 17'd7, 4'd3, '0);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'd152);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'd32);
    issue_request(ACT_FREE_ALL, 17'd0, 4'd0, '0);
    issue_request(ACT_ALLOC, 17'd65520, 4'd0, '0);
    issue_request(ACT_ALLOC, 17'd0, 4'd0, '0);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'd16);
    issue_request(ACT_ALLOC, 17'd61524, 4'd0, '0);
    issue_request(ACT_ALLOC, 17'd0, 4'd12, '0);
    issue_request(ACT_ALLOC, 17'd0, 4'd0, '0);
    issue_request(ACT_FREE, 17'd0, 4'd0, 16'd16);
    issue_request(ACT_FREE_ALL, 17'd65536, 4'd15, 16'hFFFF);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      base = BASE_W'($urandom);
      case (p)
        0: begin
          base  = '1;
          len   = OFFSET_W'(BUFFER_BYTES_DEF);
          items = 300;
        end
        1: begin
          len   = '0;
          items = 60;
        end
        2: begin
          len   = OFFSET_W'($urandom_range(16, 600));
          items = 200;
        end
        3: begin
          len   = OFFSET_W'($urandom_range(1, BUFFER_BYTES_DEF));
          items = 300;
        end
        4: begin
          len   = OFFSET_W'(BUFFER_BYTES_DEF - 1);
          items = 300;
        end
        default: begin
          base  = '0;
          len   = OFFSET_W'(BUFFER_BYTES_DEF);
          items = 370;
        end
      endcase
      set_config(base, len);
      calm = (p == 3);
      for (int i = 0; i < items; i++) begin
        if (p == NUM_PHASES - 1 && i >= items - CALM_TAIL) calm = 1'b1;
        issue_random_request();
      end
      drain();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    run_done = 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
